@@ sv/penc_pkg.sv @@
`default_nettype none

package penc_pkg;

	localparam int TAPS = 6;
	localparam int TAIL_LEN = 6;
	localparam int PHASE_W = 3;
	localparam int TAIL_W = 3;

	localparam logic [TAPS:0] POLY_G1 = 7'o171;
	localparam logic [TAPS:0] POLY_G2 = 7'o133;

	localparam logic [1:0] RATE_HALF = 2'd0;
	localparam logic [1:0] RATE_TWO_THIRDS = 2'd1;
	localparam logic [1:0] RATE_THREE_QUARTERS = 2'd2;

	typedef struct packed {
		logic shift_en;
		logic din;
	} penc_shift_ctl_t;

	typedef struct packed {
		logic g1;
		logic g2;
	} penc_pair_t;

	typedef struct packed {
		logic keep;
		logic [PHASE_W-1:0] next_phase;
	} penc_punct_t;

	// one coded position through the puncture pattern
	function automatic penc_punct_t punct_step(input logic [1:0] rate,
		input logic [PHASE_W-1:0] phase);
		penc_punct_t r;
		logic [PHASE_W-1:0] p;
		r = '0;
		p = phase;
		unique case (rate)
			RATE_TWO_THIRDS: begin
				p = {1'b0, phase[1:0]};
				r.keep = (p != 3'd2);
				r.next_phase = {1'b0, 2'(p[1:0] + 2'd1)};
			end
			RATE_THREE_QUARTERS: begin
				if (phase > 3'd5) begin
					p = 3'd0;
				end
				r.keep = !((p == 3'd2) || (p == 3'd5));
				r.next_phase = (p == 3'd5) ? 3'd0 : 3'(p + 3'd1);
			end
			default: begin
				// no puncturing, phase left alone
				r.keep = 1'b1;
				r.next_phase = phase;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/penc_cell.sv @@
`default_nettype none

module penc_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic d,
	output logic      q
);

	logic tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= 1'b0;
		end else if (en) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;

endmodule

`default_nettype wire

@@ sv/penc_shift_chain.sv @@
`default_nettype none

module penc_shift_chain (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire penc_pkg::penc_shift_ctl_t ctl,
	output penc_pkg::penc_pair_t           pair
);

	logic [penc_pkg::TAPS-1:0] taps;
	logic [penc_pkg::TAPS:0]   window;

	// newest bit enters the top cell and walks down one cell per shift
	for (genvar i = 0; i < penc_pkg::TAPS; i++) begin : g_cell
		logic d;
		if (i == penc_pkg::TAPS - 1) begin : g_head
			assign d = ctl.din;
		end else begin : g_link
			assign d = taps[i+1];
		end
		penc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (ctl.shift_en),
			.d      (d),
			.q      (taps[i])
		);
	end

	assign window = {ctl.din, taps};

	always_comb begin
		pair.g1 = ^(window & penc_pkg::POLY_G1);
		pair.g2 = ^(window & penc_pkg::POLY_G2);
	end

endmodule

`default_nettype wire

@@ sv/punctured_conv_encoder_k7.sv @@
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    data_bit, append_tail
// out      out  out_valid / out_ready  coded_bit, run_last
// cfg      in   cfg_we                 cfg_wdata (code rate)
//
// each information bit is encoded into a two-slot buffer that drains one kept bit per
// cycle while out_ready allows; the next item is taken as the last buffered bit leaves,
// and an item with tail also pushes the tail zeros through, fewer bits where punctured.
// the output register drains while the next item is accepted.
// arst_n clears the shift cells, puncture phase, code rate and all valid flags.
// out_ready low with a bit pending holds the output register and the buffer; input waits unless the buffer is empty.

`default_nettype none

module punctured_conv_encoder_k7 (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       data_bit,
	input  wire logic       append_tail,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            coded_bit,
	output logic            run_last,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata
);

	localparam int PW = penc_pkg::PHASE_W;
	localparam int TW = penc_pkg::TAIL_W;

	logic [1:0]    code_rate_q;
	logic [PW-1:0] phase_q;
	logic [TW-1:0] tail_cnt_q;
	logic [1:0]    slot_vld_q;
	logic [1:0]    slot_bit_q;
	logic [1:0]    slot_last_q;
	logic          out_valid_q;
	logic          coded_q;
	logic          last_q;

	logic out_free, slots_any, pop, empty_next, idle_tail;
	logic accept, load_tail, load, final_pair, punctured;
	logic pop_sel, pop_bit, pop_last;
	logic [1:0] slot_vld_d;

	penc_pkg::penc_shift_ctl_t chain_ctl;
	penc_pkg::penc_pair_t      pair;
	penc_pkg::penc_punct_t     ps0, ps1;

	penc_shift_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.pair   (pair)
	);

	always_comb begin
		out_free   = !out_valid_q || out_ready;
		slots_any  = |slot_vld_q;
		pop        = out_free && slots_any;
		// buffer is free next cycle: empty now, or its last bit leaves now
		empty_next = !slots_any || (out_free && (slot_vld_q != 2'b11));
		idle_tail  = (tail_cnt_q == '0);
		in_ready   = empty_next && idle_tail;
		accept     = in_valid && in_ready;
		load_tail  = empty_next && !idle_tail;
		load       = accept || load_tail;
		final_pair = accept ? !append_tail : (tail_cnt_q == TW'(1));

		chain_ctl.shift_en = load;
		chain_ctl.din      = accept ? data_bit : 1'b0;

		punctured = (code_rate_q == penc_pkg::RATE_TWO_THIRDS) ||
			(code_rate_q == penc_pkg::RATE_THREE_QUARTERS);
		ps0 = penc_pkg::punct_step(code_rate_q, phase_q);
		ps1 = penc_pkg::punct_step(code_rate_q, ps0.next_phase);

		pop_sel  = !slot_vld_q[0];
		pop_bit  = slot_bit_q[pop_sel];
		pop_last = slot_last_q[pop_sel];

		slot_vld_d = slot_vld_q;
		if (load) begin
			slot_vld_d = {ps1.keep, ps0.keep};
		end else if (pop) begin
			slot_vld_d[pop_sel] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_rate_q <= penc_pkg::RATE_HALF;
			phase_q     <= '0;
			tail_cnt_q  <= '0;
			slot_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				code_rate_q <= cfg_wdata;
			end
			if (load) begin
				phase_q <= (load_tail && (tail_cnt_q == TW'(1))) ? '0 : ps1.next_phase;
			end
			if (accept && append_tail) begin
				tail_cnt_q <= TW'(penc_pkg::TAIL_LEN);
			end else if (load_tail) begin
				tail_cnt_q <= tail_cnt_q - TW'(1);
			end
			slot_vld_q <= slot_vld_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_bit_q  <= {pair.g2 ^ !punctured, pair.g1};
			slot_last_q <= {final_pair, final_pair && !ps1.keep};
		end
		if (pop) begin
			coded_q <= pop_bit;
			last_q  <= pop_last;
		end
	end

	assign out_valid = out_valid_q;
	assign coded_bit = coded_q;
	assign run_last  = last_q;

`ifndef SYNTH
	// every encoded bit keeps at least one of its pair
	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (slot_vld_q != 2'b00))
		else $error("encoded bit produced no kept bit");

	// the end-of-run beat leaves nothing pending behind it
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_last) |-> (idle_tail && (slot_vld_q != 2'b11)))
		else $error("run_last issued with work still pending");

	a_tail_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(load_tail && (tail_cnt_q == TW'(1))) |=> ((phase_q == '0) && (tail_cnt_q == '0)))
		else $error("tail end did not clear phase");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_cnt_q <= TW'(penc_pkg::TAIL_LEN))
		else $error("tail counter out of range");
`endif

endmodule

`default_nettype wire
